// ----- rtl/core/rlab_pkg.sv -----
// Shared types and constants for the run-length alpha glyph blender.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package rlab_pkg;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_SURFACE_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SURFACE_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BLEND_COLOR    = 3'd4;
    localparam int unsigned CFG_DATA_W = 24;

    // mask stream codes
    localparam logic [7:0] CODE_ESCAPE   = 8'h00;
    localparam logic [7:0] CMD_NEXT_ROW  = 8'h00;
    localparam logic [7:0] CMD_GLYPH_END = 8'hFF;

    // front-to-back queue
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0]  code_byte;
        logic [23:0] dest_pixel;
    } rlab_in_t;

    typedef struct packed {
        logic        write_enable;
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [23:0] new_pixel;
        logic [11:0] cursor_x;
        logic [11:0] cursor_y;
        logic        done_res;
        logic        clipped;
    } rlab_out_t;

    typedef struct packed {
        logic [12:0]        surface_width;
        logic [12:0]        surface_height;
        logic signed [13:0] origin_x;
        logic signed [13:0] origin_y;
        logic [23:0]        blend_color;
    } rlab_cfg_t;

    // classified item handed from front to back
    typedef struct packed {
        logic        write_enable;
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [8:0]  alpha;
        logic [23:0] dest_pixel;
        logic [11:0] cursor_x;
        logic [11:0] cursor_y;
        logic        done_res;
        logic        clipped;
    } rlab_work_t;

    typedef struct packed {
        logic full;
        logic empty;
    } rlab_queue_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/rlab_front.sv -----
// Front end: accepts mask bytes, runs the escape decoder and cursor, classifies.
// Depends on rlab_pkg.
`default_nettype none

module rlab_front #(
    parameter int GLYPH_WIDTH  = 6,
    parameter int GLYPH_HEIGHT = 11
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire rlab_pkg::rlab_cfg_t          cfg,
    input  wire logic                         code_valid,
    output logic                              code_stall,
    input  wire rlab_pkg::rlab_in_t           code_data,
    input  wire rlab_pkg::rlab_queue_status_t q_status,
    output logic                              push,
    output rlab_pkg::rlab_work_t              work
);

    localparam logic [7:0]  GW     = 8'(GLYPH_WIDTH);
    localparam logic [7:0]  GH     = 8'(GLYPH_HEIGHT);
    localparam logic [14:0] GW_EXT = 15'(GLYPH_WIDTH);
    localparam logic [14:0] GH_EXT = 15'(GLYPH_HEIGHT);

    logic       esc_reg, esc_next;
    logic [7:0] col_reg, col_next;
    logic [7:0] row_reg, row_next;

    logic              fits;
    logic signed [14:0] x_end, y_end;
    logic [7:0]        b;
    logic              we;
    logic              done;

    assign code_stall = q_status.full;
    assign push       = code_valid && !q_status.full;
    assign b          = code_data.code_byte;

    always_comb
    begin
        x_end = {cfg.origin_x[13], cfg.origin_x} + signed'(GW_EXT);
        y_end = {cfg.origin_y[13], cfg.origin_y} + signed'(GH_EXT);
        fits  = !cfg.origin_x[13] && !cfg.origin_y[13] &&
                (x_end <= signed'({2'b00, cfg.surface_width})) &&
                (y_end <= signed'({2'b00, cfg.surface_height}));
    end

    always_comb
    begin
        esc_next = esc_reg;
        col_next = col_reg;
        row_next = row_reg;
        we       = 1'b0;
        done     = 1'b0;
        if (esc_reg)
        begin
            esc_next = 1'b0;
            if (b == rlab_pkg::CMD_NEXT_ROW)
            begin
                row_next = row_reg + 8'd1;
                col_next = 8'd0;
            end
            else if (b == rlab_pkg::CMD_GLYPH_END)
            begin
                row_next = 8'd0;
                col_next = 8'd0;
                done     = 1'b1;
            end
            else
            begin
                col_next = col_reg + b;
            end
        end
        else if (b == rlab_pkg::CODE_ESCAPE)
        begin
            esc_next = 1'b1;
        end
        else
        begin
            we       = fits && (col_reg < GW) && (row_reg < GH);
            col_next = col_reg + 8'd1;
        end
    end

    always_comb
    begin
        work.write_enable = we;
        work.pixel_x      = we ? (cfg.origin_x[11:0] + {4'd0, col_reg}) : 12'd0;
        work.pixel_y      = we ? (cfg.origin_y[11:0] + {4'd0, row_reg}) : 12'd0;
        work.alpha        = {1'b0, b} + {8'd0, b[7]};
        work.dest_pixel   = code_data.dest_pixel;
        work.cursor_x     = cfg.origin_x[11:0] + {4'd0, col_next};
        work.cursor_y     = cfg.origin_y[11:0] + {4'd0, row_next};
        work.done_res     = done;
        work.clipped      = !fits;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg <= 1'b0;
            col_reg <= 8'd0;
            row_reg <= 8'd0;
        end
        else if (push)
        begin
            esc_reg <= esc_next;
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // a command byte always closes the escape
    assert property (@(posedge clk) disable iff (!rst_n) (push && esc_reg) |=> !esc_reg)
        else $error("escape still pending after command byte");

endmodule

`default_nettype wire

// ----- rtl/core/rlab_queue.sv -----
// Short queue between the decoder front and the blend back end.
// Depends on rlab_pkg.
`default_nettype none

module rlab_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire rlab_pkg::rlab_work_t push_data,
    input  wire logic                 pop,
    output rlab_pkg::rlab_work_t      pop_data,
    output rlab_pkg::rlab_queue_status_t status
);

    localparam int unsigned DEPTH = rlab_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = rlab_pkg::QUEUE_PTR_W;
    localparam int unsigned CNT_W = rlab_pkg::QUEUE_CNT_W;
    localparam logic [PTR_W-1:0] LAST  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULLC = CNT_W'(DEPTH);

    rlab_pkg::rlab_work_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == FULLC);
    assign status.empty = (count_reg == '0);
    assign pop_data     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= FULLC)
        else $error("queue count beyond depth");
    assert property (@(posedge clk) disable iff (!rst_n) status.empty |-> !pop)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- rtl/core/rlab_back.sv -----
// Back end: pops classified items, blends the color, holds the output register.
// Depends on rlab_pkg.
`default_nettype none

module rlab_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire rlab_pkg::rlab_cfg_t          cfg,
    input  wire rlab_pkg::rlab_queue_status_t q_status,
    input  wire rlab_pkg::rlab_work_t         work,
    output logic                              pop,
    output logic                              pix_valid,
    input  wire logic                         pix_stall,
    output rlab_pkg::rlab_out_t               pix_data
);

    // old + floor(alpha * (tgt - old) / 256), low 8 bits
    function automatic logic [7:0] blend_chan(input logic [7:0] old,
                                              input logic [7:0] tgt,
                                              input logic [8:0] alpha);
        logic signed [8:0]  diff;
        logic signed [19:0] prod;
        diff = signed'({1'b0, tgt}) - signed'({1'b0, old});
        prod = signed'({1'b0, alpha}) * diff;
        return old + prod[15:8];
    endfunction

    logic                valid_reg;
    rlab_pkg::rlab_out_t data_reg, data_next;

    assign pop       = !q_status.empty && (!valid_reg || !pix_stall);
    assign pix_valid = valid_reg;
    assign pix_data  = data_reg;

    always_comb
    begin
        data_next.write_enable = work.write_enable;
        data_next.pixel_x      = work.pixel_x;
        data_next.pixel_y      = work.pixel_y;
        data_next.new_pixel    = '0;
        if (work.write_enable)
            data_next.new_pixel = {
                blend_chan(work.dest_pixel[23:16], cfg.blend_color[23:16], work.alpha),
                blend_chan(work.dest_pixel[15:8],  cfg.blend_color[15:8],  work.alpha),
                blend_chan(work.dest_pixel[7:0],   cfg.blend_color[7:0],   work.alpha)};
        data_next.cursor_x     = work.cursor_x;
        data_next.cursor_y     = work.cursor_y;
        data_next.done_res     = work.done_res;
        data_next.clipped      = work.clipped;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (!pix_stall)
            valid_reg <= 1'b0;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !data_reg.write_enable) |->
        (data_reg.new_pixel == '0 && data_reg.pixel_x == '0 && data_reg.pixel_y == '0))
        else $error("non-write result carries pixel data");

endmodule

`default_nettype wire

// ----- rtl/core/rle_alpha_glyph_blender.sv -----
// Top level of the run-length alpha glyph blender: config registers, front,
// queue and back end. Depends on rlab_pkg, rlab_front, rlab_queue, rlab_back.
//
// Use: the code channel (code_valid/code_stall/code_data) carries one request
// per mask byte with the surface pixel at the cursor; the pix channel returns
// exactly one result per request, in order. A request is taken at an edge where
// valid is high and stall is low.
// Throughput: one request per cycle while the queue is not full, set by the single
// blend stage (three 9x9 multiplies) feeding the output register.
// Path: an accepted request is written to a queue entry, then blended into the
// output register, which raises pix_valid.
// Stall: when pix_stall holds the result, the two-entry queue keeps absorbing
// requests; code_stall rises only when that queue is full.
// Config: cfg_valid/cfg_ready/cfg_index/cfg_data, always ready; indexes beyond
// the register list are ignored. Writes belong between glyphs, with the block idle.
// Reset: rst_n clears config registers, escape state, cursor (column 0, row 0),
// empties the queue and drops pix_valid.
`default_nettype none

module rle_alpha_glyph_blender #(
    parameter int GLYPH_WIDTH  = 6,
    parameter int GLYPH_HEIGHT = 11
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  code_valid,
    output logic                                       code_stall,
    input  wire rlab_pkg::rlab_in_t                    code_data,
    output logic                                       pix_valid,
    input  wire logic                                  pix_stall,
    output rlab_pkg::rlab_out_t                        pix_data,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [rlab_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [rlab_pkg::CFG_DATA_W-1:0]       cfg_data
);

    rlab_pkg::rlab_cfg_t          cfg_reg;
    rlab_pkg::rlab_queue_status_t q_status;
    rlab_pkg::rlab_work_t         push_work, pop_work;
    logic                         push, pop;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rlab_pkg::REG_SURFACE_WIDTH:  cfg_reg.surface_width  <= cfg_data[12:0];
                rlab_pkg::REG_SURFACE_HEIGHT: cfg_reg.surface_height <= cfg_data[12:0];
                rlab_pkg::REG_ORIGIN_X:       cfg_reg.origin_x       <= signed'(cfg_data[13:0]);
                rlab_pkg::REG_ORIGIN_Y:       cfg_reg.origin_y       <= signed'(cfg_data[13:0]);
                rlab_pkg::REG_BLEND_COLOR:    cfg_reg.blend_color    <= cfg_data;
                default: ;
            endcase
        end
    end

    // front: decode and classify
    rlab_front #(
        .GLYPH_WIDTH  (GLYPH_WIDTH),
        .GLYPH_HEIGHT (GLYPH_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .code_valid (code_valid),
        .code_stall (code_stall),
        .code_data  (code_data),
        .q_status   (q_status),
        .push       (push),
        .work       (push_work)
    );

    // decoupling queue
    rlab_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_work),
        .pop       (pop),
        .pop_data  (pop_work),
        .status    (q_status)
    );

    // back: blend and output register
    rlab_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_status  (q_status),
        .work      (pop_work),
        .pop       (pop),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data)
    );

endmodule

`default_nettype wire
